[design/aabb_frustum_cull_test_macros.svh]
// assertion macros for the frustum cull test checker
`ifndef AABB_FRUSTUM_CULL_TEST_MACROS_SVH
`define AABB_FRUSTUM_CULL_TEST_MACROS_SVH

// clocked assertion, off during reset
`define AFCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion, also checked across reset
`define AFCT_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/afct_pkg.sv]
// package: request codes, defaults and pipeline control type for the frustum cull test
`timescale 1ns / 1ps
package afct_pkg;
   localparam int DEFAULT_FRAC_BITS = 16;

   localparam logic [1:0] REQ_LOAD_VP    = 2'd0;
   localparam logic [1:0] REQ_LOAD_MODEL = 2'd1;
   localparam logic [1:0] REQ_TEST       = 2'd2;
   localparam logic [1:0] REQ_IGNORED    = 2'd3;

   typedef struct packed {
      logic vld;
      logic corner;
      logic first;
      logic last;
      logic ovf;
      logic ld_model;
      logic ld_vp;
   } ctl_type;
endpackage

[design/aabb_frustum_cull_test.sv]
// top level: pipelined box against frustum cull test in signed fixed point
//
// usage
// - input channel: a transaction is taken at a rising edge with start high and busy low.
//   req_type selects loading a view-projection entry, loading a model entry or testing
//   a box; a fourth code is taken and ignored.
// - loads give no response; busy stays low after them.
// - a box test walks its 8 corners through the pipe, one corner per cycle; busy is high
//   from after the test is taken until its last corner is issued, blocking new transactions.
// - the rate is set by the single corner transform datapath (12 model and 16
//   view-projection multipliers) that each corner uses once.
// - loads travel down the pipe and update a matrix where that matrix is read, so each
//   test sees exactly the loads taken before it.
// - response: rsp_strobe is high for one cycle with rsp_visible and rsp_range_overflow,
//   registered once the last corner has left stage s4. The receiver cannot stall the block.
// - reset clears the pipe, the corner sequencer and the response strobe; matrix
//   contents are undefined until written.
`timescale 1ns / 1ps
module aabb_frustum_cull_test
   import afct_pkg::*;
#(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [3:0]         req_entry_index,
   input  logic signed [31:0] req_entry_value,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic [30:0]        req_size_x,
   input  logic [30:0]        req_size_y,
   input  logic [30:0]        req_size_z,
   output logic               rsp_strobe,
   output logic               rsp_visible,
   output logic               rsp_range_overflow
);
   localparam int PW = 64 - FRAC_BITS;
   localparam int SW = PW + 2;

   function automatic logic fits32(input logic signed [SW-1:0] s);
      return (&s[SW-1:31]) | ~(|s[SW-1:31]);
   endfunction

   logic accept;
   logic issuing_ff, issuing_in;
   logic [2:0] cnt_ff, cnt_in;
   logic signed [31:0] center_ff [3];
   logic [29:0] half_ff [3];

   logic signed [31:0] c_sel [3];
   logic [29:0] h_sel [3];
   logic [2:0] corner_idx;
   logic signed [32:0] v_comb [3];
   logic v_ovf;

   ctl_type s0_in, s0_ff, s1_ff, s2_ff, s3_ff, s4_ff;
   ctl_type s2_in, s4_in;
   logic signed [32:0] s0_v_ff [3];
   logic [3:0] s0_idx_ff, s1_idx_ff, s2_idx_ff;
   logic signed [31:0] s0_val_ff, s1_val_ff, s2_val_ff;

   logic signed [31:0] model_ff [16];
   logic signed [31:0] vp_ff [16];

   logic signed [PW-1:0] p1_in [12];
   logic signed [PW-1:0] p1_ff [12];
   logic signed [31:0] bias_ff [4];
   logic signed [SW-1:0] w_sum [4];
   logic w_ovf;
   logic signed [31:0] world_ff [4];

   logic signed [PW-1:0] p2_in [16];
   logic signed [PW-1:0] p2_ff [16];
   logic signed [SW-1:0] c_sum [4];
   logic c_ovf;
   logic signed [31:0] clip_ff [4];

   logic [5:0] planes;
   logic [5:0] acc_ff, acc_in;
   logic ovf_acc_ff, ovf_acc_in;
   logic rsp_strobe_ff, rsp_visible_ff, rsp_ovf_ff;

   assign accept = start && !busy;
   assign busy = issuing_ff;

   always_comb begin
      issuing_in = issuing_ff;
      cnt_in = cnt_ff;
      if (issuing_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            issuing_in = 1'b0;
         end
      end else if (accept && req_type == REQ_TEST) begin
         issuing_in = 1'b1;
         cnt_in = 3'd1;
      end
   end

   always_comb begin
      c_sel[0] = issuing_ff ? center_ff[0] : req_center_x;
      c_sel[1] = issuing_ff ? center_ff[1] : req_center_y;
      c_sel[2] = issuing_ff ? center_ff[2] : req_center_z;
      h_sel[0] = issuing_ff ? half_ff[0] : req_size_x[30:1];
      h_sel[1] = issuing_ff ? half_ff[1] : req_size_y[30:1];
      h_sel[2] = issuing_ff ? half_ff[2] : req_size_z[30:1];
      corner_idx = issuing_ff ? cnt_ff : 3'd0;
      v_ovf = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (corner_idx[k]) begin
            v_comb[k] = 33'(c_sel[k]) + $signed({3'b000, h_sel[k]});
         end else begin
            v_comb[k] = 33'(c_sel[k]) - $signed({3'b000, h_sel[k]});
         end
         if (v_comb[k][32] != v_comb[k][31]) begin
            v_ovf = 1'b1;
         end
      end
      s0_in = '0;
      if (issuing_ff) begin
         s0_in.vld = 1'b1;
         s0_in.corner = 1'b1;
         s0_in.last = (cnt_ff == 3'd7);
         s0_in.ovf = v_ovf;
      end else if (accept) begin
         s0_in.vld = (req_type != REQ_IGNORED);
         s0_in.corner = (req_type == REQ_TEST);
         s0_in.first = (req_type == REQ_TEST);
         s0_in.ovf = (req_type == REQ_TEST) && v_ovf;
         s0_in.ld_model = (req_type == REQ_LOAD_MODEL);
         s0_in.ld_vp = (req_type == REQ_LOAD_VP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         cnt_ff <= 3'd0;
         s0_ff <= '0;
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
         s4_ff <= '0;
         acc_ff <= '0;
         ovf_acc_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         issuing_ff <= issuing_in;
         cnt_ff <= cnt_in;
         s0_ff <= s0_in;
         s1_ff <= s0_ff;
         s2_ff <= s2_in;
         s3_ff <= s2_ff;
         s4_ff <= s4_in;
         acc_ff <= acc_in;
         ovf_acc_ff <= ovf_acc_in;
         rsp_strobe_ff <= s4_ff.vld && s4_ff.corner && s4_ff.last;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept && !issuing_ff && req_type == REQ_TEST) begin
         center_ff[0] <= req_center_x;
         center_ff[1] <= req_center_y;
         center_ff[2] <= req_center_z;
         half_ff[0] <= req_size_x[30:1];
         half_ff[1] <= req_size_y[30:1];
         half_ff[2] <= req_size_z[30:1];
      end
      for (int k = 0; k < 3; k++) begin
         s0_v_ff[k] <= v_comb[k];
      end
      s0_idx_ff <= req_entry_index;
      s0_val_ff <= req_entry_value;
      s1_idx_ff <= s0_idx_ff;
      s1_val_ff <= s0_val_ff;
      s2_idx_ff <= s1_idx_ff;
      s2_val_ff <= s1_val_ff;
      if (s0_ff.vld && s0_ff.ld_model) begin
         model_ff[s0_idx_ff] <= s0_val_ff;
      end
      if (s2_ff.vld && s2_ff.ld_vp) begin
         vp_ff[s2_idx_ff] <= s2_val_ff;
      end
      p1_ff <= p1_in;
      for (int r = 0; r < 4; r++) begin
         bias_ff[r] <= model_ff[r*4+3];
         world_ff[r] <= w_sum[r][31:0];
         clip_ff[r] <= c_sum[r][31:0];
      end
      p2_ff <= p2_in;
      rsp_visible_ff <= ovf_acc_in | ~(|acc_in);
      rsp_ovf_ff <= ovf_acc_in;
   end

   // model transform products, floored
   always_comb begin
      logic signed [63:0] p;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            p = model_ff[r*4+c] * $signed(s0_v_ff[c][31:0]);
            p1_in[r*3+c] = $signed(p[63:FRAC_BITS]);
         end
      end
   end

   always_comb begin
      w_ovf = 1'b0;
      for (int r = 0; r < 4; r++) begin
         w_sum[r] = SW'(p1_ff[r*3]) + SW'(p1_ff[r*3+1]) + SW'(p1_ff[r*3+2])
                  + SW'(bias_ff[r]);
         if (!fits32(w_sum[r])) begin
            w_ovf = 1'b1;
         end
      end
   end

   // overflow flags picked up along the pipe
   always_comb begin
      s2_in = s1_ff;
      s2_in.ovf = s1_ff.ovf | (s1_ff.corner & w_ovf);
      s4_in = s3_ff;
      s4_in.ovf = s3_ff.ovf | (s3_ff.corner & c_ovf);
   end

   // view-projection products, floored
   always_comb begin
      logic signed [63:0] p;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            p = vp_ff[r*4+c] * world_ff[c];
            p2_in[r*4+c] = $signed(p[63:FRAC_BITS]);
         end
      end
   end

   always_comb begin
      c_ovf = 1'b0;
      for (int r = 0; r < 4; r++) begin
         c_sum[r] = SW'(p2_ff[r*4]) + SW'(p2_ff[r*4+1]) + SW'(p2_ff[r*4+2])
                  + SW'(p2_ff[r*4+3]);
         if (!fits32(c_sum[r])) begin
            c_ovf = 1'b1;
         end
      end
   end

   // plane tests and corner accumulation
   always_comb begin
      logic signed [32:0] w_pos;
      logic signed [32:0] w_neg;
      logic signed [32:0] cv;
      w_pos = 33'(clip_ff[3]);
      w_neg = -w_pos;
      for (int a = 0; a < 3; a++) begin
         cv = 33'(clip_ff[a]);
         planes[2*a] = cv < w_neg;
         planes[2*a+1] = cv > w_pos;
      end
      acc_in = acc_ff;
      ovf_acc_in = ovf_acc_ff;
      if (s4_ff.vld && s4_ff.corner) begin
         if (s4_ff.first) begin
            acc_in = planes;
            ovf_acc_in = s4_ff.ovf;
         end else begin
            acc_in = acc_ff & planes;
            ovf_acc_in = ovf_acc_ff | s4_ff.ovf;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_visible = rsp_visible_ff;
   assign rsp_range_overflow = rsp_ovf_ff;
endmodule

[design/afct_checker.sv]
// port checker for the frustum cull test and its bind
`timescale 1ns / 1ps
`include "aabb_frustum_cull_test_macros.svh"
module afct_checker
   import afct_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_type,
   input logic       rsp_strobe,
   input logic       rsp_visible,
   input logic       rsp_range_overflow
);
   `AFCT_ASSERT(test_sets_busy, start && !busy && req_type == REQ_TEST |=> busy, "test transaction did not raise busy")
   `AFCT_ASSERT(load_keeps_idle, start && !busy && req_type != REQ_TEST |=> !busy, "non-test transaction raised busy")
   `AFCT_ASSERT(ovf_forces_visible, rsp_strobe && rsp_range_overflow |-> rsp_visible, "overflow without visible")
   `AFCT_ASSERT(strobe_spaced, rsp_strobe |=> !rsp_strobe, "responses in adjacent cycles")
   `AFCT_ASSERT_RST(reset_clears, reset |=> !rsp_strobe && !busy, "reset left strobe or busy set")
endmodule

bind aabb_frustum_cull_test afct_checker u_afct_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_type(req_type),
   .rsp_strobe(rsp_strobe),
   .rsp_visible(rsp_visible),
   .rsp_range_overflow(rsp_range_overflow)
);
